FILE: rtl/slmd_pkg.sv
// ----------------------------------------------------------------------------
// slmd_pkg
// Shared widths and codes of the sorted list merge and difference unit.
// ----------------------------------------------------------------------------
package slmd_pkg;

   localparam int VALUE_W = 32;
   localparam int REQ_W   = 2;
   localparam int CLASS_W = 2;

   // Request codes; the fourth code is unused and ignored.
   localparam logic [REQ_W-1:0] REQ_LOAD_NEW = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOAD_OLD = 2'd1;
   localparam logic [REQ_W-1:0] REQ_END_ROW  = 2'd2;

   // Edge classes.
   localparam logic [CLASS_W-1:0] CLS_DELETED   = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_ADDED     = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_UNCHANGED = 2'd2;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [CLASS_W-1:0] class_type;

endpackage

FILE: rtl/slmd_req_if.sv
// ----------------------------------------------------------------------------
// slmd_req_if
// Request channel: list loads and end-of-row items.
// ----------------------------------------------------------------------------
interface slmd_req_if;

   logic                            valid;
   logic                            ready;
   logic [slmd_pkg::REQ_W-1:0]      req_type;
   slmd_pkg::value_type             neighbor_value;
   slmd_pkg::value_type             row_node;

   modport source (output valid, output req_type, output neighbor_value,
                   output row_node, input ready);
   modport sink   (input valid, input req_type, input neighbor_value,
                   input row_node, output ready);

endinterface

FILE: rtl/slmd_rsp_if.sv
// ----------------------------------------------------------------------------
// slmd_rsp_if
// Response channel: one classified edge per neighbour of a row.
// ----------------------------------------------------------------------------
interface slmd_rsp_if;

   logic                  valid;
   logic                  ready;
   slmd_pkg::value_type   out_node;
   slmd_pkg::value_type   out_neighbor;
   slmd_pkg::class_type   edge_class;
   logic                  list_overflow;
   logic                  last_of_row;

   modport source (output valid, output out_node, output out_neighbor,
                   output edge_class, output list_overflow,
                   output last_of_row, input ready);
   modport sink   (input valid, input out_node, input out_neighbor,
                   input edge_class, input list_overflow,
                   input last_of_row, output ready);

endinterface

FILE: rtl/slmd_list_ram.sv
// ----------------------------------------------------------------------------
// slmd_list_ram
// Single-port-write, single-port-read list store with a registered read.
// ----------------------------------------------------------------------------
module slmd_list_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  slmd_pkg::value_type  wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output slmd_pkg::value_type  rd_data
);

   slmd_pkg::value_type mem [DEPTH];
   slmd_pkg::value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sorted_list_merge_diff_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_merge_diff_unit
// Per-row set difference of a new and a previous sorted neighbour list.
// ----------------------------------------------------------------------------
// Usage: a row is sent on the request channel as new-list loads and
// previous-list loads in any interleaving, followed by one end-of-row
// request carrying the node id. Each load returns nothing; loads past
// LIST_DEPTH entries are dropped and the row's overflow flag is raised.
// The end-of-row request starts a two-way merge over the two list
// memories, and every neighbour leaves on the response channel classed
// as deleted, added or unchanged, the last one flagged. Each merge step
// first reads both list heads from the synchronous memories in its read
// step and then compares and registers the response in its compare step.
// A row with both lists empty returns nothing. Requests are refused while
// a merge runs. If the receiver stalls, the merge holds in its compare
// step with the response register full and resumes as soon as that
// response is taken. A synchronous reset empties both lists and clears
// the overflow flag; list contents are not cleared, as only entries
// below the fill counts are ever read.
// ----------------------------------------------------------------------------
module sorted_list_merge_diff_unit #(
   parameter int LIST_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   slmd_req_if.sink    req,
   slmd_rsp_if.source  rsp
);

   localparam int CW        = $clog2(LIST_DEPTH + 1);
   localparam int AW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int MEM_DEPTH = 1 << AW;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_CMP  = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        new_count_ff, new_count_in;
   logic [CW-1:0]        old_count_ff, old_count_in;
   logic [CW-1:0]        ui_ff, ui_in;
   logic [CW-1:0]        pi_ff, pi_in;
   logic                 ovf_ff, ovf_in;
   slmd_pkg::value_type  node_ff, node_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   slmd_pkg::value_type  rsp_neighbor_ff, rsp_neighbor_in;
   slmd_pkg::class_type  rsp_class_ff, rsp_class_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic                 rsp_last_ff, rsp_last_in;
   slmd_pkg::value_type  rsp_node_ff, rsp_node_in;

   logic                 req_fire;
   logic                 new_wr, old_wr;
   logic                 rd_en;
   slmd_pkg::value_type  new_head, old_head;
   logic                 new_left, old_left;
   logic                 out_free;
   logic                 emit;
   logic [CW-1:0]        ui_step, pi_step;

   // ------------------------------------------------------------------
   // List memories. Loads write at the fill count; the merge reads both
   // heads together in the read step.
   // ------------------------------------------------------------------
   assign req_fire = req.valid && req.ready;
   assign new_wr   = req_fire && (req.req_type == slmd_pkg::REQ_LOAD_NEW)
                     && (new_count_ff < CW'(LIST_DEPTH));
   assign old_wr   = req_fire && (req.req_type == slmd_pkg::REQ_LOAD_OLD)
                     && (old_count_ff < CW'(LIST_DEPTH));
   assign rd_en    = (state_ff == ST_READ);

   slmd_list_ram #(.DEPTH(MEM_DEPTH), .ADDR_W(AW)) u_new_ram (
      .clock   (clock),
      .wr_en   (new_wr),
      .wr_addr (new_count_ff[AW-1:0]),
      .wr_data (req.neighbor_value),
      .rd_en   (rd_en),
      .rd_addr (ui_ff[AW-1:0]),
      .rd_data (new_head)
   );

   slmd_list_ram #(.DEPTH(MEM_DEPTH), .ADDR_W(AW)) u_old_ram (
      .clock   (clock),
      .wr_en   (old_wr),
      .wr_addr (old_count_ff[AW-1:0]),
      .wr_data (req.neighbor_value),
      .rd_en   (rd_en),
      .rd_addr (pi_ff[AW-1:0]),
      .rd_data (old_head)
   );

   // ------------------------------------------------------------------
   // Merge control. The compare step only proceeds when the response
   // register is empty or being emptied in this cycle.
   // ------------------------------------------------------------------
   assign new_left = (ui_ff < new_count_ff);
   assign old_left = (pi_ff < old_count_ff);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = (state_ff == ST_CMP) && out_free;

   always_comb begin
      // Choose the class, value and pointer moves of this merge step.
      ui_step         = ui_ff;
      pi_step         = pi_ff;
      rsp_neighbor_in = rsp_neighbor_ff;
      rsp_class_in    = rsp_class_ff;
      if (!new_left) begin
         rsp_neighbor_in = old_head;
         rsp_class_in    = slmd_pkg::CLS_DELETED;
         pi_step         = pi_ff + CW'(1);
      end else if (!old_left) begin
         rsp_neighbor_in = new_head;
         rsp_class_in    = slmd_pkg::CLS_ADDED;
         ui_step         = ui_ff + CW'(1);
      end else if (old_head < new_head) begin
         rsp_neighbor_in = old_head;
         rsp_class_in    = slmd_pkg::CLS_DELETED;
         pi_step         = pi_ff + CW'(1);
      end else if (old_head > new_head) begin
         rsp_neighbor_in = new_head;
         rsp_class_in    = slmd_pkg::CLS_ADDED;
         ui_step         = ui_ff + CW'(1);
      end else begin
         rsp_neighbor_in = old_head;
         rsp_class_in    = slmd_pkg::CLS_UNCHANGED;
         pi_step         = pi_ff + CW'(1);
         ui_step         = ui_ff + CW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      new_count_in = new_count_ff;
      old_count_in = old_count_ff;
      ui_in        = ui_ff;
      pi_in        = pi_ff;
      ovf_in       = ovf_ff;
      node_in      = node_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_node_in  = rsp_node_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req.req_type)
                  slmd_pkg::REQ_LOAD_NEW: begin
                     if (new_wr) begin
                        new_count_in = new_count_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  slmd_pkg::REQ_LOAD_OLD: begin
                     if (old_wr) begin
                        old_count_in = old_count_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  slmd_pkg::REQ_END_ROW: begin
                     node_in = req.row_node;
                     ui_in   = '0;
                     pi_in   = '0;
                     if ((new_count_ff == '0) && (old_count_ff == '0)) begin
                        // Nothing to merge: just start the next row.
                        ovf_in = 1'b0;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = ovf_ff;
               rsp_node_in  = node_ff;
               rsp_last_in  = (ui_step == new_count_ff) && (pi_step == old_count_ff);
               ui_in        = ui_step;
               pi_in        = pi_step;
               if (rsp_last_in) begin
                  state_in     = ST_IDLE;
                  new_count_in = '0;
                  old_count_in = '0;
                  ovf_in       = 1'b0;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         new_count_ff <= '0;
         old_count_ff <= '0;
         ui_ff        <= '0;
         pi_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         new_count_ff <= new_count_in;
         old_count_ff <= old_count_in;
         ui_ff        <= ui_in;
         pi_ff        <= pi_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      if (emit) begin
         rsp_neighbor_ff <= rsp_neighbor_in;
         rsp_class_ff    <= rsp_class_in;
      end
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
      rsp_node_ff <= rsp_node_in;
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_node      = rsp_node_ff;
   assign rsp.out_neighbor  = rsp_neighbor_ff;
   assign rsp.edge_class    = rsp_class_ff;
   assign rsp.list_overflow = rsp_ovf_ff;
   assign rsp.last_of_row   = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // A compare step always has at least one list element left to class.
   a_cmp_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (new_left || old_left))
      else $error("merge step with both lists exhausted");

   // While a merge runs, the read pointers never run past the fill counts.
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((ui_ff <= new_count_ff) && (pi_ff <= old_count_ff)))
      else $error("merge pointer beyond list fill");

   // Fill counts stay within the list depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (new_count_ff <= CW'(LIST_DEPTH)) && (old_count_ff <= CW'(LIST_DEPTH)))
      else $error("list fill count beyond depth");

   // The final response of a row returns the block to idle with empty lists.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_last_in) |=>
         ((state_ff == ST_IDLE) && (new_count_ff == '0) && (old_count_ff == '0)
          && !ovf_ff))
      else $error("row state not cleared after last response");

   // Loads are only accepted while no merge is running.
   a_no_load_in_merge: assert property (@(posedge clock) disable iff (reset)
      (new_wr || old_wr) |-> (state_ff == ST_IDLE))
      else $error("list written during merge");

endmodule

FILE: dv/tb_sorted_list_merge_diff_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_merge_diff_unit
// Self-checking bench for the sorted list merge and difference unit. Rows of
// new-list and previous-list loads, each closed by an end-of-row request, are
// driven with random gaps. A scoreboard merges each row on its own and checks
// every classified edge that comes back, in order, field by field.
// ----------------------------------------------------------------------------
module tb_sorted_list_merge_diff_unit;

   localparam int LIST_DEPTH = 32;

   // The fourth request code has no meaning; the unit must ignore it.
   localparam logic [slmd_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

   // One classified edge as the response channel presents it.
   typedef struct {
      slmd_pkg::value_type node;
      slmd_pkg::value_type neighbor;
      slmd_pkg::class_type edge_cls;
      logic                overflow;
      logic                last;
   } edge_rec_type;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of both lists, the fill counts and the
   // overflow flag. Every accepted request is noted; an end-of-row request
   // runs the merge and queues the edges that the unit should return.
   // -------------------------------------------------------------------------
   class edge_diff_board_type;
      slmd_pkg::value_type new_mem[LIST_DEPTH];
      slmd_pkg::value_type old_mem[LIST_DEPTH];
      int                  new_fill;
      int                  old_fill;
      bit                  dropped;
      edge_rec_type        expected_edges[$];
      int                  errors;

      function void note_request(logic [slmd_pkg::REQ_W-1:0] code,
                                 slmd_pkg::value_type value,
                                 slmd_pkg::value_type node);
         case (code)
            slmd_pkg::REQ_LOAD_NEW: begin
               if (new_fill < LIST_DEPTH) begin
                  new_mem[new_fill] = value;
                  new_fill++;
               end else begin
                  dropped = 1'b1;
               end
            end
            slmd_pkg::REQ_LOAD_OLD: begin
               if (old_fill < LIST_DEPTH) begin
                  old_mem[old_fill] = value;
                  old_fill++;
               end else begin
                  dropped = 1'b1;
               end
            end
            slmd_pkg::REQ_END_ROW: merge_row(node);
            default: ;
         endcase
      endfunction

      // Two-way merge over whatever order was loaded; unsigned compares.
      function void merge_row(slmd_pkg::value_type node);
         int           ui = 0;
         int           pi = 0;
         edge_rec_type row_edges[$];
         edge_rec_type e;
         while (ui < new_fill || pi < old_fill) begin
            e.node     = node;
            e.overflow = dropped;
            e.last     = 1'b0;
            if (ui >= new_fill) begin
               e.neighbor = old_mem[pi];
               e.edge_cls = slmd_pkg::CLS_DELETED;
               pi++;
            end else if (pi >= old_fill) begin
               e.neighbor = new_mem[ui];
               e.edge_cls = slmd_pkg::CLS_ADDED;
               ui++;
            end else if (old_mem[pi] < new_mem[ui]) begin
               e.neighbor = old_mem[pi];
               e.edge_cls = slmd_pkg::CLS_DELETED;
               pi++;
            end else if (old_mem[pi] > new_mem[ui]) begin
               e.neighbor = new_mem[ui];
               e.edge_cls = slmd_pkg::CLS_ADDED;
               ui++;
            end else begin
               e.neighbor = old_mem[pi];
               e.edge_cls = slmd_pkg::CLS_UNCHANGED;
               pi++;
               ui++;
            end
            row_edges = {row_edges, e};
         end
         if (row_edges.size() > 0) row_edges[row_edges.size()-1].last = 1'b1;
         expected_edges = {expected_edges, row_edges};
         new_fill = 0;
         old_fill = 0;
         dropped  = 1'b0;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_edge(slmd_pkg::value_type node, slmd_pkg::value_type neighbor,
                               slmd_pkg::class_type edge_cls, logic overflow, logic last);
         edge_rec_type want;
         if (expected_edges.size() == 0) begin
            $error("unexpected edge: node 0x%0h neighbour 0x%0h class %0d",
                   node, neighbor, edge_cls);
            errors++;
         end else begin
            want = expected_edges.pop_front();
            compare_field("out_node", want.node, node);
            compare_field("out_neighbor", want.neighbor, neighbor);
            compare_field("edge_class", 32'(want.edge_cls), 32'(edge_cls));
            compare_field("list_overflow", 32'(want.overflow), 32'(overflow));
            compare_field("last_of_row", 32'(want.last), 32'(last));
         end
      endfunction

      function int pending();
         return expected_edges.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   slmd_req_if req_if ();
   slmd_rsp_if rsp_if ();

   sorted_list_merge_diff_unit #(
      .LIST_DEPTH (LIST_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   edge_diff_board_type board = new;

   int items_sent;    // accepted requests, ignored codes not counted
   bit gappy;         // the sender may idle between requests of this row
   bit quiet;         // closing stretch: neither side idles
   bit hold_off_rsp;  // asks the receiver for one long stall

   always #2 clock = ~clock;

   // Both channels are sampled at the clock edge, before any update driven
   // at that same edge can be seen, so acceptance is judged on settled values.
   always @(posedge clock) begin
      if (!reset && req_if.valid === 1'b1 && req_if.ready === 1'b1)
         board.note_request(req_if.req_type, req_if.neighbor_value, req_if.row_node);
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         board.check_edge(rsp_if.out_node, rsp_if.out_neighbor, rsp_if.edge_class,
                          rsp_if.list_overflow, rsp_if.last_of_row);
   end

   // Receiver: ready in random stretches with random stall bursts.
   // Once asked, it holds off for a long stretch so that the response register
   // stays full, the merge stops and the request channel backs up behind it.
   initial begin
      @(posedge clock);
      forever begin
         if (hold_off_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Offers one request and holds it until the unit takes it. Called at a
   // clock edge; returns at the edge of acceptance, or after a gap.
   task automatic send_request(logic [slmd_pkg::REQ_W-1:0] code,
                               slmd_pkg::value_type value, slmd_pkg::value_type node);
      req_if.valid          <= 1'b1;
      req_if.req_type       <= code;
      req_if.neighbor_value <= value;
      req_if.row_node       <= node;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      if (code != REQ_UNUSED) items_sent++;
      if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // The sender stays quiet until every expected edge has come back. The
   // first edge lets the scoreboard note a request taken at this very edge.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Neighbour ids: the extremes, small values that collide often, and the
   // full 32-bit range. A narrow row draws from a tiny range only, which
   // gives many equal heads and repeated entries.
   function automatic slmd_pkg::value_type pick_value(bit narrow);
      if (narrow) return slmd_pkg::value_type'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return slmd_pkg::value_type'($urandom_range(0, 40));
         default: return slmd_pkg::value_type'($urandom);
      endcase
   endfunction

   // One row: about half of the previous list is copied from the new list so
   // that unchanged edges are common. Ordered rows are sorted as the unit
   // expects; the others exercise the merge on arbitrary load order. Loads of
   // the two lists are interleaved at random, with the odd ignored code.
   task automatic send_row(int n_new, int n_old, bit ordered, bit narrow);
      slmd_pkg::value_type new_vals[$];
      slmd_pkg::value_type old_vals[$];
      slmd_pkg::value_type node;
      node = pick_value(1'b0);
      repeat (n_new) new_vals = {new_vals, pick_value(narrow)};
      repeat (n_old) begin
         if (new_vals.size() > 0 && $urandom_range(0, 1) == 0)
            old_vals = {old_vals, new_vals[$urandom_range(0, new_vals.size() - 1)]};
         else
            old_vals = {old_vals, pick_value(narrow)};
      end
      if (ordered) begin
         new_vals.sort();
         old_vals.sort();
      end
      while (new_vals.size() + old_vals.size() > 0) begin
         if ($urandom_range(0, 24) == 0)
            send_request(REQ_UNUSED, slmd_pkg::value_type'($urandom),
                         slmd_pkg::value_type'($urandom));
         if (old_vals.size() == 0 || (new_vals.size() != 0 && $urandom_range(0, 1) == 0))
            send_request(slmd_pkg::REQ_LOAD_NEW, new_vals.pop_front(),
                         slmd_pkg::value_type'($urandom));
         else
            send_request(slmd_pkg::REQ_LOAD_OLD, old_vals.pop_front(),
                         slmd_pkg::value_type'($urandom));
      end
      send_request(slmd_pkg::REQ_END_ROW, slmd_pkg::value_type'($urandom), node);
   endtask

   // Hard stop in case the unit hangs: many times the slowest clean run.
   initial begin
      #400_000;
      $display("tb_sorted_list_merge_diff_unit: done, errors");
      $finish;
   end

   initial begin
      int row_idx;
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.req_type       = slmd_pkg::REQ_LOAD_NEW;
      req_if.neighbor_value = '0;
      req_if.row_node       = '0;
      rsp_if.ready          = 1'b0;
      items_sent            = 0;
      gappy                 = 1'b1;
      quiet                 = 1'b0;
      hold_off_rsp          = 1'b0;
      row_idx               = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed rows. A row with both lists empty must return nothing.
      send_request(slmd_pkg::REQ_END_ROW, '0, '0);
      // Lone new entry of zero, then a lone previous entry of all ones.
      send_request(slmd_pkg::REQ_LOAD_NEW, '0, '1);
      send_request(slmd_pkg::REQ_END_ROW, '1, '1);
      send_request(slmd_pkg::REQ_LOAD_OLD, '1, '0);
      send_request(slmd_pkg::REQ_END_ROW, '0, 32'h5555_5555);
      // Equal heads at the top of the range give one unchanged edge.
      send_request(slmd_pkg::REQ_LOAD_NEW, '1, 32'h0F0F_0F0F);
      send_request(slmd_pkg::REQ_LOAD_OLD, '1, 32'hF0F0_F0F0);
      send_request(slmd_pkg::REQ_END_ROW, 32'h3333_3333, 32'hAAAA_AAAA);
      // All three classes in one row, with an ignored code among the loads.
      send_request(slmd_pkg::REQ_LOAD_OLD, '0, '0);
      send_request(slmd_pkg::REQ_LOAD_NEW, 32'd5, '0);
      send_request(REQ_UNUSED, '1, '1);
      send_request(slmd_pkg::REQ_LOAD_OLD, 32'd5, '0);
      send_request(slmd_pkg::REQ_LOAD_NEW, '1, '0);
      send_request(slmd_pkg::REQ_END_ROW, 32'hCCCC_CCCC, 32'h1234_5678);
      // Unsorted new list: the merge still walks the lists in load order.
      send_request(slmd_pkg::REQ_LOAD_NEW, 32'd9, '0);
      send_request(slmd_pkg::REQ_LOAD_NEW, 32'd3, '0);
      send_request(slmd_pkg::REQ_LOAD_OLD, 32'd4, '0);
      send_request(slmd_pkg::REQ_END_ROW, '0, 32'h8765_4321);

      // The sender pauses until the directed rows have been answered.
      wait_for_drain();

      // Random rows. Most are small and sorted; every twelfth is near or past
      // the list depth, the first of those overflowing both the new list and the
      // previous list, which fills both lists to the depth.
      // Long rows stop well before the end so that the total stays close.
      while (items_sent < 350) begin
         if (items_sent >= 300) quiet = 1'b1;
         gappy = ($urandom_range(0, 2) != 0);
         // The receiver stalls for long while the sender keeps offering rows.
         if (row_idx == 8) hold_off_rsp = 1'b1;
         if (row_idx == 20) wait_for_drain();
         if (row_idx == 5)
            send_row(34, 33, 1'b1, 1'b0);
         else if (row_idx % 12 == 5 && items_sent < 280)
            send_row($urandom_range(28, 35), $urandom_range(28, 35),
                     $urandom_range(0, 3) != 0, 1'b0);
         else
            send_row($urandom_range(0, 6), $urandom_range(0, 6),
                     $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
         row_idx++;
      end

      // Let the last row drain, then watch a while for stray edges.
      wait_for_drain();
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("tb_sorted_list_merge_diff_unit: done, clean");
      else
         $display("tb_sorted_list_merge_diff_unit: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/slmd_pkg.sv
rtl/slmd_req_if.sv
rtl/slmd_rsp_if.sv
rtl/slmd_list_ram.sv
rtl/sorted_list_merge_diff_unit.sv
dv/tb_sorted_list_merge_diff_unit.sv
